/* rtl/hjs_pkg.sv */
// Package: widths, constants and CORDIC angle table for the harmonic jitter synthesizer.
package hjs_pkg;

  localparam int unsigned MaxHarmonicsDefault = 64;
  localparam int unsigned CordicStepsDefault  = 24;

  localparam int unsigned SumW = 38;
  localparam int unsigned CfgAddrW = 1;

  localparam logic [31:0] InvTwoPiQ32  = 32'd683565276;
  localparam logic [31:0] HalfPiQ30    = 32'd1686629713;
  localparam logic [31:0] CordicGainQ30 = 32'd652032875;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  localparam logic [CfgAddrW-1:0] RegHarmonicCount = 1'b0;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqEval  = 1'b1;

  // atan(2^-i) in Q1.30
  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] e;
    begin
      unique case (i)
        5'd0:  e = 34'sd843314857;
        5'd1:  e = 34'sd497837829;
        5'd2:  e = 34'sd263043837;
        5'd3:  e = 34'sd133525159;
        5'd4:  e = 34'sd67021687;
        5'd5:  e = 34'sd33543516;
        5'd6:  e = 34'sd16775851;
        5'd7:  e = 34'sd8388437;
        5'd8:  e = 34'sd4194283;
        5'd9:  e = 34'sd2097149;
        5'd10: e = 34'sd1048576;
        default: e = 34'sd1073741824 >>> i;
      endcase
      return e;
    end
  endfunction

endpackage

/* rtl/hjs_if.sv */
// Valid/ready stream interfaces for request and result channels.
interface hjs_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [5:0]  row_index;
  logic [31:0] frequency_hz;
  logic signed [31:0] sample_amplitude;
  logic signed [31:0] sample_phase;
  logic signed [31:0] line_amplitude;
  logic signed [31:0] line_phase;
  logic [31:0] eval_time;
  modport source (output valid, req_type, row_index, frequency_hz, sample_amplitude,
                  sample_phase, line_amplitude, line_phase, eval_time, input ready);
  modport sink (input valid, req_type, row_index, frequency_hz, sample_amplitude,
                sample_phase, line_amplitude, line_phase, eval_time, output ready);
endinterface

interface hjs_res_if;
  logic               valid;
  logic               ready;
  logic signed [37:0] sample_jitter;
  logic signed [37:0] line_jitter;
  modport source (output valid, sample_jitter, line_jitter, input ready);
  modport sink (input valid, sample_jitter, line_jitter, output ready);
endinterface

/* rtl/hjs_cordic.sv */
// Iterative CORDIC: cosine of a Q0.32 turn angle, one micro-rotation per cycle.
module hjs_cordic
  import hjs_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned StepW = $clog2(CordicSteps + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScale = 4'b0010,
    StRot   = 4'b0100,
    StDone  = 4'b1000
  } cst_e;

  cst_e cst_q, cst_d;
  logic [StepW-1:0] step_q, step_d;
  logic [1:0] quad_q, quad_d;
  logic signed [31:0] res_q, res_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;

  logic [31:0] quad_add;
  logic [1:0]  quad;
  logic [31:0] resid;
  logic signed [33:0] dx, dy, ang;
  logic [4:0] sh;

  always_comb begin
    quad_add = angle_i + 32'h2000_0000;
    quad     = quad_add[31:30];
    resid    = angle_i - {quad, 30'd0};
    sh       = 5'(step_q);
    dx       = y_q >>> sh;
    dy       = x_q >>> sh;
    ang      = atan_entry(sh);
  end

  always_comb begin
    cst_d  = cst_q;
    step_d = step_q;
    quad_d = quad_q;
    prod_d = prod_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    res_d = res_q;
    unique case (cst_q)
      StIdle: begin
        if (start_i) begin
          quad_d = quad;
          prod_d = $signed(resid) * $signed({1'b0, HalfPiQ30});
          cst_d  = StScale;
        end
      end
      StScale: begin
        z_d    = prod_q[63:30];
        x_d    = {2'b00, CordicGainQ30};
        y_d    = '0;
        step_d = '0;
        cst_d  = StRot;
      end
      StRot: begin
        if (!z_q[33]) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - ang;
        end else begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + ang;
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(CordicSteps - 1)) begin
          cst_d = StDone;
        end
      end
      StDone: begin
        unique case (quad_q)
          2'd0: res_d = x_q[31:0];
          2'd1: res_d = 32'(-y_q);
          2'd2: res_d = 32'(-x_q);
          default: res_d = y_q[31:0];
        endcase
        cst_d = StIdle;
      end
      default: cst_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q  <= StIdle;
      step_q <= '0;
    end else begin
      cst_q  <= cst_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    prod_q <= prod_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    res_q <= res_d;
  end

  // done pulses in the cycle after the quadrant fold, as the folded result reaches cos_o
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= (cst_q == StDone);
  end

  assign done_o = done_q;
  assign cos_o  = res_q;

endmodule

/* rtl/harmonic_jitter_synthesizer_core.sv */
// Top level: harmonic table, row sequencer, shared multiplier and CORDIC.
//
// Channel | Dir | Fields
// req     | in  | req_type, row_index, frequency_hz, amplitudes, phases, eval_time
// res     | out | sample_jitter, line_jitter
// apb     | cfg | harmonic_count at 0x0
//
// A write request is stored in the table from the SWrite state. An evaluation sums N rows
// through the single CORDIC and multiplier, each used per axis in turn.
// Table storage has no reset; harmonic_count resets to 0. req.ready is low while busy
// and while a result waits in the output register.
module harmonic_jitter_synthesizer_core
  import hjs_pkg::*;
#(
  parameter int unsigned MaxHarmonics = MaxHarmonicsDefault,
  parameter int unsigned CordicSteps  = CordicStepsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hjs_req_if.sink             req,
  hjs_res_if.source           res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW+1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned RowW = (MaxHarmonics > 1) ? $clog2(MaxHarmonics) : 1;
  localparam int unsigned CntW = $clog2(MaxHarmonics + 1);

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SWrite = 11'b00000000010,
    SRead  = 11'b00000000100,
    SCyc   = 11'b00000001000,
    SPhMul = 11'b00000010000,
    SAng   = 11'b00000100000,
    SCos   = 11'b00001000000,
    SAmp   = 11'b00010000000,
    SAcc   = 11'b00100000000,
    SNext  = 11'b01000000000,
    SOut   = 11'b10000000000
  } st_e;

  st_e st_q, st_d;

  // configuration
  logic [6:0] hcount_q;
  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrW+1:2] == RegHarmonicCount) ? {25'd0, hcount_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hcount_q <= '0;
    else if (psel && penable && pwrite && paddr[CfgAddrW+1:2] == RegHarmonicCount)
      hcount_q <= pwdata[6:0];
  end

  // table memories
  logic [31:0] freq_mem [MaxHarmonics];
  logic [31:0] samp_mem [MaxHarmonics];
  logic [31:0] sph_mem  [MaxHarmonics];
  logic [31:0] lamp_mem [MaxHarmonics];
  logic [31:0] lph_mem  [MaxHarmonics];
  logic [31:0] freq_rd, samp_rd, sph_rd, lamp_rd, lph_rd;

  // captured request
  logic [5:0]  wrow_q;
  logic [31:0] wf_q, wsa_q, wsp_q, wla_q, wlp_q, time_q;

  logic [CntW-1:0] row_q, row_d, nrows_q, nrows_d;
  logic            axis_q, axis_d;   // 0 sample, 1 line
  logic [31:0]     turns_q, turns_d;
  logic signed [63:0] mul_q, mul_d;
  logic [31:0]     ang_q, ang_d;
  logic signed [SumW-1:0] sacc_q, sacc_d, lacc_q, lacc_d;
  logic            rvalid_q, rvalid_d;
  logic signed [SumW-1:0] rs_q, rs_d, rl_q, rl_d;

  logic               cstart;
  logic               cdone;
  logic signed [31:0] cosv;

  hjs_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cstart),
    .angle_i(ang_q),
    .done_o (cdone),
    .cos_o  (cosv)
  );

  assign req.ready = (st_q == SIdle) && !rvalid_q;
  logic accept;
  assign accept = req.valid && req.ready;

  always_ff @(posedge clk_i) begin
    if (st_q == SWrite && {{(32-6){1'b0}}, wrow_q} < 32'(MaxHarmonics)) begin
      freq_mem[RowW'(wrow_q)] <= wf_q;
      samp_mem[RowW'(wrow_q)] <= wsa_q;
      sph_mem[RowW'(wrow_q)]  <= wsp_q;
      lamp_mem[RowW'(wrow_q)] <= wla_q;
      lph_mem[RowW'(wrow_q)]  <= wlp_q;
    end
    freq_rd <= freq_mem[row_q[RowW-1:0]];
    samp_rd <= samp_mem[row_q[RowW-1:0]];
    sph_rd  <= sph_mem[row_q[RowW-1:0]];
    lamp_rd <= lamp_mem[row_q[RowW-1:0]];
    lph_rd  <= lph_mem[row_q[RowW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wrow_q <= req.row_index;
      wf_q   <= req.frequency_hz;
      wsa_q  <= req.sample_amplitude;
      wsp_q  <= req.sample_phase;
      wla_q  <= req.line_amplitude;
      wlp_q  <= req.line_phase;
      time_q <= req.eval_time;
    end
  end

  // shared 33x33 multiplier operand select
  logic signed [32:0] ma, mb;
  logic signed [SumW:0] sum_w;
  logic signed [SumW-1:0] term, acc_sel, sat;
  always_comb begin
    ma = '0; mb = '0;
    unique case (st_q)
      SCyc:   begin ma = {1'b0, freq_rd}; mb = {1'b0, time_q}; end
      SPhMul: begin
        ma = axis_q ? {lph_rd[31], lph_rd} : {sph_rd[31], sph_rd};
        mb = {1'b0, InvTwoPiQ32};
      end
      SAmp: begin
        ma = axis_q ? {lamp_rd[31], lamp_rd} : {samp_rd[31], samp_rd};
        mb = {cosv[31], cosv};
      end
      default: ;
    endcase
    term    = SumW'(mul_q >>> 30);
    acc_sel = axis_q ? lacc_q : sacc_q;
    sum_w   = {acc_sel[SumW-1], acc_sel} + {term[SumW-1], term};
    if (sum_w[SumW] != sum_w[SumW-1]) sat = sum_w[SumW] ? SumMin : SumMax;
    else                              sat = sum_w[SumW-1:0];
  end

  always_comb begin
    st_d = st_q; row_d = row_q; nrows_d = nrows_q; axis_d = axis_q;
    turns_d = turns_q; mul_d = mul_q; ang_d = ang_q;
    sacc_d = sacc_q; lacc_d = lacc_q;
    rvalid_d = rvalid_q; rs_d = rs_q; rl_d = rl_q;
    cstart = 1'b0;
    if (res.valid && res.ready) rvalid_d = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (accept) begin
          if (req.req_type == ReqWrite) st_d = SWrite;
          else begin
            nrows_d = ({{(32-7){1'b0}}, hcount_q} > 32'(MaxHarmonics)) ?
                      CntW'(MaxHarmonics) : CntW'(hcount_q);
            row_d  = '0;
            sacc_d = '0; lacc_d = '0;
            st_d   = SNext;
          end
        end
      end
      SWrite: st_d = SIdle;
      SNext: begin
        axis_d = 1'b0;
        if (row_q == nrows_q) st_d = SOut;
        else                  st_d = SRead;
      end
      SRead: st_d = SCyc;
      SCyc: begin
        mul_d = ma * mb;
        st_d  = SPhMul;
      end
      SPhMul: begin
        if (!axis_q) turns_d = mul_q[35:4];
        mul_d = ma * mb;
        st_d  = SAng;
      end
      SAng: begin
        ang_d = turns_q - mul_q[59:28];
        st_d  = SCos;
      end
      SCos: begin
        cstart = !cdone;
        if (cdone) st_d = SAmp;
      end
      SAmp: begin
        mul_d = ma * mb;
        st_d  = SAcc;
      end
      SAcc: begin
        if (axis_q) begin
          lacc_d = sat;
          row_d  = row_q + 1'b1;
          st_d   = SNext;
        end else begin
          sacc_d = sat;
          axis_d = 1'b1;
          st_d   = SPhMul;
        end
      end
      SOut: begin
        rvalid_d = 1'b1;
        rs_d = sacc_q; rl_d = lacc_q;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  // first pass through SPhMul holds the cycle product; second axis reuses turns_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; rvalid_q <= 1'b0; row_q <= '0; nrows_q <= '0; axis_q <= 1'b0;
    end else begin
      st_q <= st_d; rvalid_q <= rvalid_d; row_q <= row_d; nrows_q <= nrows_d;
      axis_q <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    turns_q <= turns_d; mul_q <= mul_d; ang_q <= ang_d;
    sacc_q <= sacc_d; lacc_q <= lacc_d; rs_q <= rs_d; rl_q <= rl_d;
  end

  assign res.valid         = rvalid_q;
  assign res.sample_jitter = rs_q;
  assign res.line_jitter   = rl_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !req.ready) else $error("ready while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && !res.ready) |=> (rvalid_q && $stable(rs_q))) else $error("result lost");
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= nrows_q)) else $error("row overrun");

endmodule
